@@ hdl/ssr_pkg.sv @@
package ssr_pkg;

    // block dimensions
    localparam int WINDOW_BYTES = 8;
    localparam int MAX_LINE     = 1023;
    localparam int LEN_LIMIT    = (WINDOW_BYTES < 8) ? WINDOW_BYTES : 8;
    localparam int LINE_W       = $clog2(MAX_LINE + 1);

    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINE);
    localparam logic [7:0]        NEWLINE  = 8'd10;

    // register map of the configuration channel
    typedef enum logic [1:0] {
        CFG_SEARCH_TEXT   = 2'd0,
        CFG_SEARCH_LEN    = 2'd1,
        CFG_REPLACE_TEXT  = 2'd2,
        CFG_REPLACE_LEN   = 2'd3
    } cfg_idx_t;

    // control handed to every window cell
    typedef struct packed {
        logic       shift;
        logic [7:0] new_byte;
    } cell_ctrl_t;

    // one item's results, loaded into the burst buffer at once
    typedef struct packed {
        logic [3:0]                  n;
        logic                        err;
        logic [LEN_LIMIT-1:0][7:0]   bytes;
    } burst_load_t;

    // clamp a 4-bit length register into minimum .. LEN_LIMIT
    function automatic logic [3:0] clamp_len(logic [3:0] v, logic [3:0] minimum);
        logic [3:0] x;
        x = v;
        if (x < minimum)
        begin
            x = minimum;
        end
        if (x > 4'(LEN_LIMIT))
        begin
            x = 4'(LEN_LIMIT);
        end
        return x;
    endfunction

endpackage

@@ hdl/ssr_ifs.sv @@
// input beat: one text byte
interface ssr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

// output beat: one rewritten byte
interface ssr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       line_too_long;

    modport source (output valid, out_byte, last_of_run, line_too_long, input ready);
    modport sink   (input valid, out_byte, last_of_run, line_too_long, output ready);
endinterface

// configuration write beat
interface ssr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ssr_cell.sv @@
module ssr_cell (
    input  logic                clk,
    input  ssr_pkg::cell_ctrl_t ctrl,
    input  logic                here,
    input  logic                active,
    input  logic [7:0]          pat_byte,
    input  logic [7:0]          nbr_byte,
    output logic [7:0]          win_byte,
    output logic                match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // slot value after the incoming byte is written
    assign win_byte = here ? ctrl.new_byte : byte_reg;

    // inactive slots never block a hit
    assign match = !active || (win_byte == pat_byte);

    // on a miss the window slides toward slot zero
    assign byte_next = ctrl.shift ? nbr_byte : win_byte;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

@@ hdl/ssr_burst.sv @@
module ssr_burst (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ssr_pkg::burst_load_t load,
    output logic                 free,
    ssr_out_if.source            dst
);

    logic [ssr_pkg::LEN_LIMIT-1:0][7:0] buf_reg;
    logic [ssr_pkg::LEN_LIMIT-1:0][7:0] buf_next;
    logic [3:0]                         cnt_reg;
    logic [3:0]                         cnt_next;
    logic                               err_reg;
    logic                               err_next;
    logic                               pop;

    // head slot drives the output
    assign dst.valid         = (cnt_reg != 4'd0);
    assign dst.out_byte      = buf_reg[0];
    assign dst.last_of_run   = (cnt_reg == 4'd1);
    assign dst.line_too_long = err_reg;

    assign pop  = dst.valid && dst.ready;
    assign free = (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && dst.ready);

    // load a whole run, or shift one beat out
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (push)
        begin
            buf_next = load.bytes;
            cnt_next = load.n;
            err_next = load.err;
        end
        else if (pop)
        begin
            for (int i = 0; i < ssr_pkg::LEN_LIMIT - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
            err_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    // a run is loaded only into an empty or emptying buffer
    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && dst.ready))
        else $error("burst loaded while still holding beats");

    // fill never exceeds the depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(ssr_pkg::LEN_LIMIT))
        else $error("burst count beyond depth");

    // an error report is a single beat
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && dst.valid) |-> (cnt_reg == 4'd1))
        else $error("error report longer than one beat");

endmodule

@@ hdl/stream_substring_replace.sv @@
// latency: the first result of an input beat is shown the cycle after it is accepted
// throughput: one input beat per cycle while each beat gives at most one result and dst is
//   ready; a beat giving k results (k up to 8) stalls the input until the burst buffer,
//   which drains one beat per cycle while dst is ready, is down to its last beat
// reset: rst_n is asynchronous, active low; it empties window and burst buffer, clears
//   line count and error, and sets search length 1, other registers zero
module stream_substring_replace (
    input  logic        clk,
    input  logic        rst_n,
    ssr_in_if.sink      src,
    ssr_out_if.source   dst,
    ssr_cfg_if.sink     cfg
);

    localparam int N = ssr_pkg::LEN_LIMIT;

    // configuration registers
    logic [63:0] search_text_reg;
    logic [3:0]  search_len_reg;
    logic [63:0] replace_text_reg;
    logic [3:0]  replace_len_reg;

    // window and line state
    logic [3:0]                  count_reg;
    logic [3:0]                  count_next;
    logic [ssr_pkg::LINE_W-1:0]  line_cnt_reg;
    logic [ssr_pkg::LINE_W-1:0]  line_cnt_next;
    logic                        err_latched_reg;
    logic                        err_latched_next;

    logic [3:0]             slen;
    logic [3:0]             rlen;
    logic [3:0]             count_p;
    logic                   accept;
    logic                   cfg_wr;
    logic                   err_now;
    logic                   step;
    logic                   full;
    logic                   hit;
    logic                   flush;
    logic                   free;
    logic [N-1:0]           match;
    logic [N-1:0][7:0]      win;
    ssr_pkg::cell_ctrl_t    cell_ctrl;
    ssr_pkg::burst_load_t   load;

    assign slen = ssr_pkg::clamp_len(search_len_reg, 4'd1);
    assign rlen = ssr_pkg::clamp_len(replace_len_reg, 4'd0);

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign src.ready = free;
    assign accept    = src.valid && src.ready;

    // item classification
    assign err_now = accept && !err_latched_reg && (line_cnt_reg >= ssr_pkg::LINE_MAX);
    assign step    = accept && !err_latched_reg && !err_now;
    assign count_p = count_reg + 4'd1;
    assign full    = (count_p >= slen);
    assign hit     = full && (&match);
    assign flush   = (src.in_byte == ssr_pkg::NEWLINE) || src.end_of_input;

    assign cell_ctrl.shift    = step && full && !hit;
    assign cell_ctrl.new_byte = src.in_byte;

    // row of window cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [7:0] nbr;
        if (i == N - 1)
        begin : g_tail
            assign nbr = 8'd0;
        end
        else
        begin : g_mid
            assign nbr = win[i + 1];
        end

        ssr_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .here     (step && (count_reg == 4'(i))),
            .active   (4'(i) < slen),
            .pat_byte (search_text_reg[8*i +: 8]),
            .nbr_byte (nbr),
            .win_byte (win[i]),
            .match    (match[i])
        );
    end

    // results of this beat: replacement on a hit, one error beat on line overflow, else the window in order
    always_comb
    begin
        load.err = err_now;
        load.n   = 4'd0;
        for (int i = 0; i < N; i++)
        begin
            load.bytes[i] = hit ? replace_text_reg[8*i +: 8] : win[i];
        end
        if (err_now)
        begin
            load.n     = 4'd1;
            load.bytes = '0;
        end
        else if (step)
        begin
            if (hit)
            begin
                load.n = rlen;
            end
            else if (flush)
            begin
                load.n = count_p;
            end
            else if (full)
            begin
                load.n = 4'd1;
            end
        end
    end

    // window count, line count and sticky error
    always_comb
    begin
        count_next       = count_reg;
        line_cnt_next    = line_cnt_reg;
        err_latched_next = err_latched_reg;
        if (err_now)
        begin
            count_next       = 4'd0;
            line_cnt_next    = '0;
            err_latched_next = 1'b1;
        end
        else if (step)
        begin
            if (hit || flush)
            begin
                count_next = 4'd0;
            end
            else if (full)
            begin
                count_next = slen - 4'd1;
            end
            else
            begin
                count_next = count_p;
            end
            line_cnt_next = flush ? '0 : line_cnt_reg + 1'b1;
        end
        if (cfg_wr && (ssr_pkg::cfg_idx_t'(cfg.index) == ssr_pkg::CFG_SEARCH_LEN))
        begin
            count_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= 4'd0;
            line_cnt_reg    <= '0;
            err_latched_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            line_cnt_reg    <= line_cnt_next;
            err_latched_reg <= err_latched_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_text_reg  <= 64'd0;
            search_len_reg   <= 4'd1;
            replace_text_reg <= 64'd0;
            replace_len_reg  <= 4'd0;
        end
        else if (cfg_wr)
        begin
            case (ssr_pkg::cfg_idx_t'(cfg.index))
                ssr_pkg::CFG_SEARCH_TEXT:  search_text_reg  <= cfg.data;
                ssr_pkg::CFG_SEARCH_LEN:   search_len_reg   <= cfg.data[3:0];
                ssr_pkg::CFG_REPLACE_TEXT: replace_text_reg <= cfg.data;
                ssr_pkg::CFG_REPLACE_LEN:  replace_len_reg  <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // output side
    ssr_burst u_burst (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .load  (load),
        .free  (free),
        .dst   (dst)
    );

    // the window always holds fewer bytes than the pattern
    a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < slen)
        else $error("pending window reached pattern length");

    // the error is sticky
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_latched_reg |=> err_latched_reg)
        else $error("line error cleared without reset");

    // a line overflow empties the window and restarts the line count
    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        err_now |=> err_latched_reg && (count_reg == 4'd0) && (line_cnt_reg == '0))
        else $error("line overflow left state behind");

    // after the error no beat produces results
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_latched_reg) |-> (load.n == 4'd0))
        else $error("result produced after line error");

endmodule
